/* sv/modular_exponentiation_core_defines.svh */
// assertion macros shared by the modular exponentiation core
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MEXP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("modexp core: check failed");

// next-cycle implication, checked outside reset
`define MEXP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("modexp core: check failed");

`endif

/* sv/mexp_pkg.sv */
package mexp_pkg;

  // field widths
  localparam int VALUE_W = 8;
  localparam int EXP_W   = 16;
  localparam int MOD_W   = 9;

  // multiplier operand bits consumed per cycle
  localparam int DIGIT_W   = 2;
  localparam int STEPS     = VALUE_W / DIGIT_W;
  localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(STEPS - 1);

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPONENT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_MODULUS  = CFG_INDEX_W'(1);

  // modulus range and reset values
  localparam logic [MOD_W-1:0] MOD_MIN   = MOD_W'(2);
  localparam logic [MOD_W-1:0] MOD_MAX   = MOD_W'(256);
  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(253);
  localparam logic [EXP_W-1:0] EXP_RESET = '0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_LOAD,
    S_FINISH
  } state_t;

  // control of one modular multiplier
  typedef struct packed {
    logic load;
    logic step;
  } mm_ctrl_t;

endpackage

/* sv/mexp_mulmod.sv */
module mexp_mulmod import mexp_pkg::*; (
  input  logic               clk,
  input  mm_ctrl_t           ctrl,
  input  logic [VALUE_W-1:0] a,
  input  logic [VALUE_W-1:0] b,
  input  logic [MOD_W-1:0]   m,
  output logic [VALUE_W-1:0] r
);

  logic [VALUE_W-1:0] a_reg;
  logic [VALUE_W-1:0] b_sh;
  logic [VALUE_W-1:0] r_next;

  // one radix-2 step: r = (2r + bit*a) mod m, with r, a below m
  function automatic logic [VALUE_W-1:0] bit_step(
    input logic [VALUE_W-1:0] rin,
    input logic               bin,
    input logic [VALUE_W-1:0] ain,
    input logic [MOD_W-1:0]   min
  );
    logic [MOD_W:0] t;
    logic [MOD_W:0] m1;
    logic [MOD_W:0] m2;
    t  = {1'b0, rin, 1'b0} + (bin ? {2'b00, ain} : '0);
    m1 = {1'b0, min};
    m2 = {min, 1'b0};
    if (t >= m2) begin
      t = t - m2;
    end else if (t >= m1) begin
      t = t - m1;
    end
    return t[VALUE_W-1:0];
  endfunction

  // one digit of b, most significant bit first
  always_comb begin
    r_next = r;
    for (int i = 0; i < DIGIT_W; i++) begin
      r_next = bit_step(r_next, b_sh[VALUE_W-1-i], a_reg, m);
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_reg <= a;
      b_sh  <= b;
      r     <= '0;
    end else if (ctrl.step) begin
      b_sh  <= b_sh << DIGIT_W;
      r     <= r_next;
    end
  end

endmodule

/* sv/modular_exponentiation_core.sv */
// one item at a time: item_stall stays high until the result of the last item is loaded
//   into the output register; two 2-bit-per-cycle modular multipliers do the multiply
//   and the square of each exponent bit in the step state, then the load state updates
//   the accumulator and the square; bits above the highest set exponent bit are skipped
// reset: synchronous, clears control, exponent to 0 and modulus to 253
module modular_exponentiation_core import mexp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [VALUE_W-1:0]     value,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [VALUE_W-1:0]     residue
);

`include "modular_exponentiation_core_defines.svh"

  state_t                state;
  state_t                state_next;
  logic [EXP_W-1:0]      exponent;
  logic [MOD_W-1:0]      modulus;
  logic [MOD_W-1:0]      m_eff;
  logic [EXP_W:0]        exp_sh;
  logic [EXP_W:0]        exp_rem;
  logic [VALUE_W-1:0]    acc;
  logic [VALUE_W-1:0]    acc_next;
  logic [STEP_CNT_W-1:0] cnt;
  logic                  out_load;

  mm_ctrl_t              ctrl;
  logic [VALUE_W-1:0]    a0, b0, r0;
  logic [VALUE_W-1:0]    a1, b1, r1;

  assign cfg_ready = 1'b1;

  // clamp the modulus into its legal range
  always_comb begin
    if (modulus < MOD_MIN) begin
      m_eff = MOD_MIN;
    end else if (modulus > MOD_MAX) begin
      m_eff = MOD_MAX;
    end else begin
      m_eff = modulus;
    end
  end

  // multiplier 0 forms acc*sq, multiplier 1 forms sq*sq
  mexp_mulmod u_mul_acc (
    .clk  (clk),
    .ctrl (ctrl),
    .a    (a0),
    .b    (b0),
    .m    (m_eff),
    .r    (r0)
  );

  mexp_mulmod u_mul_sq (
    .clk  (clk),
    .ctrl (ctrl),
    .a    (a1),
    .b    (b1),
    .m    (m_eff),
    .r    (r1)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_STEP;
      end
      S_STEP: begin
        if (cnt == STEP_LAST) state_next = S_LOAD;
      end
      S_LOAD: begin
        state_next = (exp_rem == '0) ? S_FINISH : S_STEP;
      end
      S_FINISH: begin
        if (!result_valid || !result_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs and datapath control
  // the exponent shifter carries a dummy zero bit below bit 0, so the first
  // update takes value mod m from multiplier 1 as the first square
  always_comb begin
    item_stall = (state != S_IDLE);
    exp_rem    = exp_sh >> 1;
    acc_next   = exp_sh[0] ? r0 : acc;
    out_load   = 1'b0;
    ctrl       = '0;
    a0         = r1;
    b0         = acc_next;
    a1         = r1;
    b1         = r1;
    case (state)
      S_IDLE: begin
        ctrl.load = item_valid;
        a0        = VALUE_W'(1);
        b0        = '0;
        a1        = VALUE_W'(1);
        b1        = value;
      end
      S_STEP: begin
        ctrl.step = 1'b1;
      end
      S_LOAD: begin
        ctrl.load = (exp_rem != '0);
      end
      S_FINISH: begin
        out_load = !result_valid || !result_stall;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= EXP_RESET;
      modulus  <= MOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EXPONENT: exponent <= cfg_data[EXP_W-1:0];
        CFG_MODULUS:  modulus  <= cfg_data[MOD_W-1:0];
        default:      ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // exponent shifter, accumulator, digit counter, result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cnt <= '0;
        if (item_valid) begin
          exp_sh <= {exponent, 1'b0};
          acc    <= VALUE_W'(1);
        end
      end
      S_STEP: begin
        cnt <= cnt + STEP_CNT_W'(1);
      end
      S_LOAD: begin
        cnt    <= '0;
        exp_sh <= exp_rem;
        acc    <= acc_next;
      end
      default: begin
        cnt <= '0;
      end
    endcase
    if (out_load) begin
      residue <= acc;
    end
  end

  // checks
  `MEXP_ASSERT_NEXT(a_accept_starts, item_valid && !item_stall, state == S_STEP)
  `MEXP_ASSERT_NOW(a_acc_reduced, state != S_IDLE, {1'b0, acc} < m_eff)
  `MEXP_ASSERT_NOW(a_finish_exp_done, state == S_FINISH, exp_sh == '0)

endmodule

/* dv/tb_modular_exponentiation_core.sv */
module tb_modular_exponentiation_core import mexp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // register indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = CFG_INDEX_W'(3);

  // run length and timing
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 75;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  logic [VALUE_W-1:0]     value = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [VALUE_W-1:0]     residue;

  logic [VALUE_W-1:0] expected_residues[$];
  logic [VALUE_W-1:0] want_residue;
  logic [EXP_W-1:0]   cur_exponent = EXP_RESET;
  logic [MOD_W-1:0]   cur_modulus = MOD_RESET;
  bit                 sender_idle = 1'b0;
  bit                 receiver_idle = 1'b0;
  int                 stall_left = 0;
  int                 error_count = 0;
  int                 cycle_count = 0;

  modular_exponentiation_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .value        (value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .residue      (residue)
  );

  always #5 clk = ~clk;

  // value^exponent mod modulus, square-and-multiply over all exponent bits
  function automatic logic [VALUE_W-1:0] predict_residue(input logic [VALUE_W-1:0] base,
                                                         input logic [EXP_W-1:0] ex,
                                                         input logic [MOD_W-1:0] mod_reg);
    int unsigned m;
    int unsigned acc;
    int unsigned sq;
    int          b;
    m = mod_reg;
    if (m < MOD_MIN) m = MOD_MIN;
    else if (m > MOD_MAX) m = MOD_MAX;
    acc = 1 % m;
    sq  = base % m;
    for (b = 0; b < EXP_W; b++) begin
      if (ex[b]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return acc[VALUE_W-1:0];
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // one register write, cfg_valid left high for a following write
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_EXPONENT: cur_exponent = data[EXP_W-1:0];
      CFG_MODULUS:  cur_modulus = data[MOD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] ex, input logic [CFG_DATA_W-1:0] md);
    write_register(CFG_EXPONENT, ex);
    write_register(CFG_MODULUS, md);
    cfg_valid <= 1'b0;
  endtask

  // one item; item_valid stays high so a following item can go back to back
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    gap = pick_gap(sender_idle);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    value      <= v;
    do @(posedge clk); while (item_stall);
    expected_residues.push_back(predict_residue(v, cur_exponent, cur_modulus));
  endtask

  // stop sending and wait for every outstanding result, optionally settle
  task automatic wait_all_results(input bit settle);
    item_valid <= 1'b0;
    while (expected_residues.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // reset register values: exponent zero gives one for any value
  task automatic test_reset_defaults();
    send_value(8'd0);
    send_value(8'd255);
    send_value(8'd7);
    wait_all_results(1'b1);
  endtask

  // field extremes, modulus clamping, value above modulus, ignored indexes
  task automatic test_directed_corners();
    configure(16'hFFFF, 16'd256);
    send_value(8'd0);
    send_value(8'd255);
    send_value(8'd2);
    wait_all_results(1'b1);
    configure(16'd1, 16'd2);
    send_value(8'd255);
    send_value(8'd0);
    wait_all_results(1'b1);
    // modulus below range clamps to two
    configure(16'd3, 16'd0);
    send_value(8'd3);
    wait_all_results(1'b1);
    configure(16'd3, 16'd1);
    send_value(8'd5);
    wait_all_results(1'b1);
    // modulus above range clamps to 256, upper data bits dropped
    configure(16'd2, 16'd257);
    send_value(8'd255);
    wait_all_results(1'b1);
    configure(16'hAAAA, 16'hFFFF);
    send_value(8'h55);
    wait_all_results(1'b1);
    // value not below modulus
    configure(16'd5, 16'd7);
    send_value(8'd200);
    wait_all_results(1'b1);
    // zero to the zero
    configure(16'd0, 16'd256);
    send_value(8'd0);
    wait_all_results(1'b1);
    // only the top exponent bit, longest run through the bits
    configure(16'h8000, 16'd253);
    send_value(8'd3);
    wait_all_results(1'b1);
    // writes to unused indexes leave both registers alone
    configure(16'd5, 16'd11);
    write_register(CFG_SPARE_A, 16'hFFFF);
    write_register(CFG_SPARE_B, 16'h0000);
    cfg_valid <= 1'b0;
    send_value(8'd9);
    wait_all_results(1'b1);
  endtask

  // fixed settings for the first four phases, random after, random items, idling varied by phase
  task automatic test_random_settings();
    int p;
    int i;
    int r;
    logic [CFG_DATA_W-1:0] ex;
    logic [CFG_DATA_W-1:0] md;
    logic [VALUE_W-1:0]    v;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin ex = 16'hFFFF; md = 16'd256; end
        1: begin ex = 16'd0; md = 16'd2; end
        2: begin ex = 16'd1; md = 16'd255; end
        3: begin ex = 16'd3; md = 16'd253; end
        default: begin
          r  = $urandom_range(0, 99);
          ex = (r < 70) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 20));
          r  = $urandom_range(0, 99);
          if (r < 65) md = 16'($urandom_range(2, 256));
          else if (r < 75) md = 16'($urandom_range(0, 1));
          else if (r < 85) md = 16'($urandom_range(257, 511));
          else md = 16'($urandom_range(0, 65535));
        end
      endcase
      configure(ex, md);
      sender_idle   = (p % 4 == 0) || (p % 4 == 2);
      receiver_idle = (p % 4 != 1);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 80) v = 8'($urandom_range(0, 255));
        else if (r < 87) v = 8'd0;
        else if (r < 94) v = 8'd255;
        else v = 8'($urandom_range(0, 3));
        send_value(v);
        // hold the sender until everything sent so far has come back
        if (p % 2 == 0 && i == PHASE_ITEMS / 2) wait_all_results(1'b0);
      end
      wait_all_results(1'b1);
    end
  endtask

  // result stalls
  always @(posedge clk) begin
    if (stall_left == 0) stall_left = pick_gap(receiver_idle);
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_residues.size() == 0) begin
        report_mismatch($sformatf("unexpected result residue=%0d", residue));
      end else begin
        want_residue = expected_residues.pop_front();
        if (residue !== want_residue)
          report_mismatch($sformatf("residue got %0d want %0d", residue, want_residue));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_modular_exponentiation_core NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_corners();
    test_random_settings();
    wait_all_results(1'b1);
    if (error_count == 0) begin
      $display("tb_modular_exponentiation_core OK");
    end else begin
      $display("tb_modular_exponentiation_core NOT OK");
    end
    $finish;
  end

endmodule

/* modular_exponentiation_core.f */
+incdir+sv
sv/mexp_pkg.sv
sv/mexp_mulmod.sv
sv/modular_exponentiation_core.sv
dv/tb_modular_exponentiation_core.sv
